FILE: hdl/ndyd_pkg.sv
// shared types, codes and constants of the nibble delta yuv422 decoder
`default_nettype none
package ndyd_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam int CHANNELS = 3;

	localparam logic [15:0] LINE_WIDTH_RESET = 16'd640;
	localparam logic [23:0] CAPACITY_RESET = 24'd614400;

	// nibble codes
	localparam logic [3:0] NIB_SKIP_LO = 4'hD;
	localparam logic [3:0] NIB_ESCAPE = 4'hF;
	// adding 250 modulo 256 is the same as subtracting the delta offset of 6
	localparam logic [7:0] DELTA_BIAS = 8'd250;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_FRAME_CAPACITY = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,
		CMD_START = 2'd1,
		CMD_END = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_DELTA = 2'd1,
		OP_LITERAL = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic dropped;
		logic frame_done;
		logic [23:0] bytes_used;
		logic last_of_run;
	} out_item_t;

	// one classified nibble: a delta carries the nibble, a literal the whole byte
	typedef struct packed {
		op_kind_t kind;
		logic [7:0] val;
	} nib_op_t;

	typedef struct packed {
		cmd_t kind;
		nib_op_t op_hi;
		nib_op_t op_lo;
	} work_t;

	// uyvy order: u, y, v, y
	function automatic logic [1:0] chan_of_phase(input logic [1:0] phase);
		logic [1:0] chan;
		unique case (phase)
			2'd0: chan = 2'd0;
			2'd2: chan = 2'd2;
			default: chan = 2'd1;
		endcase
		return chan;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ndyd_fifo.sv
// small first-in first-out queue with registered storage
`default_nettype none
module ndyd_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input T wdata,
	input logic pop,
	output logic empty,
	output T rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ndyd_front.sv
// front end: accepts items and classifies both nibbles of a data byte
`default_nettype none
module ndyd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ndyd_pkg::in_item_t data,
	output logic wq_push,
	input logic wq_full,
	output ndyd_pkg::work_t wq_data
);
	import ndyd_pkg::*;

	typedef enum logic [1:0] {
		MODE_DELTA = 2'd0,
		MODE_LIT_HI = 2'd1,
		MODE_LIT_LO = 2'd2
	} mode_t;

	typedef struct packed {
		nib_op_t op;
		mode_t mode;
		logic [3:0] lit_hi;
	} step_t;

	function automatic step_t nib_step(input mode_t mode, input logic [3:0] lit_hi,
			input logic [3:0] nib);
		step_t s;
		s.op.kind = OP_NONE;
		s.op.val = {lit_hi, nib};
		s.mode = MODE_DELTA;
		s.lit_hi = lit_hi;
		unique case (mode)
			MODE_LIT_HI: begin
				s.mode = MODE_LIT_LO;
				s.lit_hi = nib;
			end
			MODE_LIT_LO: begin
				s.op.kind = OP_LITERAL;
			end
			default: begin
				if (nib < NIB_SKIP_LO) begin
					s.op.kind = OP_DELTA;
					s.op.val = {4'h0, nib};
				end else if (nib == NIB_ESCAPE) begin
					s.mode = MODE_LIT_HI;
				end
			end
		endcase
		return s;
	endfunction

	mode_t mode_q;
	logic [3:0] lit_hi_q;
	step_t hi_step;
	step_t lo_step;
	logic accept;
	cmd_t cmd;

	// literal tracking never depends on what the back end does with the bytes
	always_comb begin
		cmd = cmd_t'(data.cmd);
		hi_step = nib_step(mode_q, lit_hi_q, data.in_byte[7:4]);
		lo_step = nib_step(hi_step.mode, hi_step.lit_hi, data.in_byte[3:0]);
		accept = push && !wq_full;
		full = wq_full;
		wq_push = accept && (cmd != CMD_SPARE);
		wq_data.kind = cmd;
		wq_data.op_hi = hi_step.op;
		wq_data.op_lo = lo_step.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DELTA;
			lit_hi_q <= '0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				mode_q <= MODE_DELTA;
				lit_hi_q <= '0;
			end else if (cmd == CMD_DATA) begin
				mode_q <= lo_step.mode;
				lit_hi_q <= lo_step.lit_hi;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ndyd_back.sv
// back end: configuration registers, channel state, one decoded byte per unstalled cycle
`default_nettype none
module ndyd_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ndyd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ndyd_pkg::CFG_DATA_W-1:0] cfg_data,
	input ndyd_pkg::work_t work,
	input logic work_empty,
	output logic work_pop,
	output ndyd_pkg::out_item_t res,
	output logic res_push,
	input logic res_full
);
	import ndyd_pkg::*;

	logic [15:0] line_width_q;
	logic [23:0] frame_capacity_q;
	logic [7:0] last_q [CHANNELS];
	logic [1:0] phase_q;
	logic [16:0] line_pos_q;
	logic [23:0] wr_pos_q;
	logic sel_q;

	logic lo_slot;
	nib_op_t op;
	logic step;
	logic [1:0] chan;
	logic [7:0] prev;
	logic [7:0] byte_val;
	logic drop;
	logic [16:0] line_inc;
	logic line_wrap;
	logic is_data;
	logic is_end;
	logic emit_byte;
	logic write_byte;

	assign cfg_ready = 1'b1;

	always_comb begin
		// an empty high slot lets the low slot go in the same cycle
		lo_slot = sel_q || (work.op_hi.kind == OP_NONE);
		op = lo_slot ? work.op_lo : work.op_hi;
		step = !work_empty && !res_full;
		is_data = (work.kind == CMD_DATA);
		is_end = (work.kind == CMD_END);
		chan = chan_of_phase(phase_q);
		prev = last_q[chan];
		if (op.kind == OP_LITERAL) begin
			byte_val = op.val;
		end else begin
			byte_val = prev + op.val + DELTA_BIAS;
		end
		drop = (wr_pos_q >= frame_capacity_q);
		line_inc = line_pos_q + 17'd1;
		line_wrap = (line_inc == {line_width_q, 1'b0});
		emit_byte = step && is_data && (op.kind != OP_NONE);
		write_byte = emit_byte && !drop;
		res_push = emit_byte || (step && is_end);
		// an empty low slot is skipped
		work_pop = step && (!is_data || lo_slot || (work.op_lo.kind == OP_NONE));
		if (is_end) begin
			res.out_byte = '0;
			res.dropped = 1'b0;
			res.frame_done = 1'b1;
			res.bytes_used = wr_pos_q;
			res.last_of_run = 1'b1;
		end else begin
			res.out_byte = byte_val;
			res.dropped = drop;
			res.frame_done = 1'b0;
			res.bytes_used = '0;
			res.last_of_run = lo_slot || (work.op_lo.kind == OP_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
			frame_capacity_q <= CAPACITY_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i] <= '0;
			end
			phase_q <= '0;
			line_pos_q <= '0;
			wr_pos_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_LINE_WIDTH: line_width_q <= cfg_data[15:0];
					REG_FRAME_CAPACITY: frame_capacity_q <= cfg_data;
					default: ;
				endcase
			end
			if (step) begin
				sel_q <= !work_pop;
				if (work.kind == CMD_START) begin
					for (int i = 0; i < CHANNELS; i++) begin
						last_q[i] <= '0;
					end
					phase_q <= '0;
					line_pos_q <= '0;
					wr_pos_q <= '0;
				end else if (write_byte) begin
					wr_pos_q <= wr_pos_q + 24'd1;
					phase_q <= phase_q + 2'd1;
					if (line_wrap) begin
						for (int i = 0; i < CHANNELS; i++) begin
							last_q[i] <= '0;
						end
						line_pos_q <= '0;
					end else begin
						last_q[chan] <= byte_val;
						line_pos_q <= line_inc;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/nibble_delta_yuv422_decoder_core.sv
// top level of the nibble delta yuv422 decoder
// Usage:
// - input side is a queue: write an item with push while full is low; cmd 0 carries a
//   compressed byte, cmd 1 starts a frame, cmd 2 ends it, cmd 3 is dropped.
// - result side is a queue: while empty is low the oldest result is on result; pop takes it.
//   a data byte gives zero, one or two decoded bytes, a frame end gives one report.
// - configuration: cfg_index 0 line width, 1 frame capacity, written when cfg_valid is high;
//   cfg_ready is always high. write only while no item is in flight.
// - path: an accepted item is registered in the work queue and its results in the result
//   queue; of an item that yields two, the first result comes out before the second.
// - throughput: one item per cycle when it yields at most one result and nothing stalls; an
//   item that yields two holds the work queue until its second byte is written; the back end
//   writes one decoded byte per cycle into the result queue while work waits and it has room.
// - reset clears the queues and all channel state and loads line width 640 and capacity
//   614400.
// - when the receiver stops popping, the result queue fills, the back end holds, the work
//   queue fills and full rises; nothing is lost.
`default_nettype none
module nibble_delta_yuv422_decoder_core #(
	parameter int WORK_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ndyd_pkg::in_item_t data,
	input logic pop,
	output logic empty,
	output ndyd_pkg::out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ndyd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ndyd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ndyd_pkg::*;

	logic wq_push;
	logic wq_full;
	work_t wq_wdata;
	logic wq_pop;
	logic wq_empty;
	work_t wq_rdata;
	logic res_push;
	logic res_full;
	out_item_t res_wdata;

	ndyd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data(data),
		.wq_push(wq_push),
		.wq_full(wq_full),
		.wq_data(wq_wdata)
	);

	ndyd_fifo #(.T(work_t), .DEPTH(WORK_DEPTH)) u_work_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(wq_push),
		.full(wq_full),
		.wdata(wq_wdata),
		.pop(wq_pop),
		.empty(wq_empty),
		.rdata(wq_rdata)
	);

	ndyd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.work(wq_rdata),
		.work_empty(wq_empty),
		.work_pop(wq_pop),
		.res(res_wdata),
		.res_push(res_push),
		.res_full(res_full)
	);

	ndyd_fifo #(.T(out_item_t), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.full(res_full),
		.wdata(res_wdata),
		.pop(pop),
		.empty(empty),
		.rdata(result)
	);
endmodule
`default_nettype wire

FILE: hdl/ndyd_checker.sv
// port level checks of the decoder, bound to the top level
`default_nettype none
module ndyd_checker (
	input logic clk,
	input logic arst_n,
	input logic pop,
	input logic empty,
	input ndyd_pkg::out_item_t result
);
	import ndyd_pkg::*;

	// a frame end report is always the single, final result of its item
	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_done |->
			result.last_of_run && (result.out_byte == '0) && !result.dropped)
		else $error("frame end report malformed");

	a_byte_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.frame_done |-> (result.bytes_used == '0))
		else $error("byte result carries a byte count");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");
endmodule

bind nibble_delta_yuv422_decoder_core ndyd_checker u_ndyd_checker (.*);
`default_nettype wire

FILE: dv/nibble_delta_yuv422_decoder_core_test.sv
// testbench of the nibble delta yuv422 decoder core: directed and random streams
`default_nettype none
module nibble_delta_yuv422_decoder_core_test;
	import ndyd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [7:0] DELTA_OFFSET = 8'd6;
	localparam logic [23:0] CAPACITY_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		NM_DELTA = 2'd0,
		NM_LIT_HI = 2'd1,
		NM_LIT_LO = 2'd2
	} nib_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t data = '0;
	logic pop = 1'b0;
	logic empty;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	nibble_delta_yuv422_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data(data),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the decoder
	logic [15:0] line_width;
	logic [23:0] frame_cap;
	logic [7:0] last_val [3];
	logic [1:0] phase;
	logic [16:0] line_pos;
	logic [23:0] write_pos;
	nib_mode_t nib_mode;
	logic [3:0] lit_high;
	out_item_t step_out [2];
	int step_n;

	out_item_t pending_results [$];

	bit tx_idle;
	bit rx_idle;
	bit rx_block;
	int rx_wait;
	int cycle_count;
	int mismatches;
	int items_sent;
	int results_seen;
	int drops_seen;
	int reports_seen;
	out_item_t got;
	out_item_t want;

	function automatic int uyvy_chan(input logic [1:0] ph);
		if (ph == 2'd0)
			return 0;
		if (ph == 2'd2)
			return 2;
		return 1;
	endfunction

	function automatic void clear_decoder();
		last_val[0] = '0;
		last_val[1] = '0;
		last_val[2] = '0;
		phase = '0;
		line_pos = '0;
		write_pos = '0;
		nib_mode = NM_DELTA;
		lit_high = '0;
	endfunction

	function automatic void write_byte(input logic [7:0] b);
		out_item_t r;
		r = '0;
		r.out_byte = b;
		if (write_pos >= frame_cap) begin
			// past capacity: reported, nothing else moves
			r.dropped = 1'b1;
		end else begin
			write_pos = write_pos + 24'd1;
			last_val[uyvy_chan(phase)] = b;
			phase = phase + 2'd1;
			line_pos = line_pos + 17'd1;
			if (line_pos == {line_width, 1'b0}) begin
				last_val[0] = '0;
				last_val[1] = '0;
				last_val[2] = '0;
				line_pos = '0;
			end
		end
		step_out[step_n] = r;
		step_n++;
	endfunction

	function automatic void decode_nibble(input logic [3:0] nib);
		logic [7:0] v;
		case (nib_mode)
			NM_LIT_HI: begin
				lit_high = nib;
				nib_mode = NM_LIT_LO;
			end
			NM_LIT_LO: begin
				nib_mode = NM_DELTA;
				write_byte({lit_high, nib});
			end
			default: begin
				nib_mode = NM_DELTA;
				if (nib < NIB_SKIP_LO) begin
					v = last_val[uyvy_chan(phase)] + {4'h0, nib} - DELTA_OFFSET;
					write_byte(v);
				end else if (nib == NIB_ESCAPE) begin
					nib_mode = NM_LIT_HI;
				end
			end
		endcase
	endfunction

	function automatic void decode_item(input in_item_t it);
		out_item_t r;
		step_n = 0;
		case (it.cmd)
			CMD_DATA: begin
				decode_nibble(it.in_byte[7:4]);
				decode_nibble(it.in_byte[3:0]);
			end
			CMD_START: clear_decoder();
			CMD_END: begin
				r = '0;
				r.frame_done = 1'b1;
				r.bytes_used = write_pos;
				step_out[0] = r;
				step_n = 1;
			end
			default: ;
		endcase
		for (int i = 0; i < step_n; i++) begin
			r = step_out[i];
			r.last_of_run = (i == step_n - 1);
			pending_results.push_back(r);
		end
	endfunction

	task automatic note_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// result side: draw a wait per result taken, or hold off entirely while rx_block is set
	always @(negedge clk) begin
		if (rx_block || rx_wait > 0) begin
			pop <= 1'b0;
			if (!rx_block)
				rx_wait--;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("status: fail");
			$finish;
		end else if (arst_n && pop && !empty) begin
			got = result;
			results_seen++;
			if (got.dropped)
				drops_seen++;
			if (got.frame_done)
				reports_seen++;
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected item byte %02h drop %0b done %0b used %0d",
					got.out_byte, got.dropped, got.frame_done, got.bytes_used));
			end else begin
				want = pending_results.pop_front();
				if (got.out_byte !== want.out_byte || got.dropped !== want.dropped ||
						got.frame_done !== want.frame_done ||
						got.bytes_used !== want.bytes_used ||
						got.last_of_run !== want.last_of_run)
					note_error($sformatf(
						"exp byte %02h drop %0b done %0b used %0d last %0b, got %02h %0b %0b %0d %0b",
						want.out_byte, want.dropped, want.frame_done, want.bytes_used,
						want.last_of_run, got.out_byte, got.dropped, got.frame_done,
						got.bytes_used, got.last_of_run));
			end
			rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
		end
	end

	task automatic send_item(input cmd_t c, input logic [7:0] b);
		int gap;
		in_item_t it;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		it.cmd = c;
		it.in_byte = b;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		data <= it;
		do @(posedge clk); while (full);
		decode_item(it);
		if (c != CMD_SPARE)
			items_sent++;
	endtask

	// lower push and let every expected result come out, then let the pipe settle
	task automatic drain_results();
		int waited;
		@(negedge clk);
		push <= 1'b0;
		waited = 0;
		while (pending_results.size() > 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() > 0) begin
			note_error($sformatf("%0d expected results never came", pending_results.size()));
			pending_results.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LINE_WIDTH)
			line_width = val[15:0];
		else
			frame_cap = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] width, input logic [23:0] cap);
		drain_results();
		write_reg(REG_LINE_WIDTH, {8'h00, width});
		write_reg(REG_FRAME_CAPACITY, cap);
	endtask

	function automatic logic [3:0] pick_nibble();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 4'($urandom_range(0, 12));
		if (r < 80)
			return 4'($urandom_range(13, 14));
		return NIB_ESCAPE;
	endfunction

	// reset values, every nibble class, literals across items and across a frame end
	task automatic test_decode_basics();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_item(CMD_START, 8'hFF);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, 8'hC6);
		send_item(CMD_DATA, 8'hDE);
		send_item(CMD_DATA, 8'hF1);
		send_item(CMD_DATA, 8'h2F);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_DATA, 8'hAB);
		send_item(CMD_SPARE, 8'hFF);
		send_item(CMD_DATA, 8'h7F);
		send_item(CMD_END, 8'h00);
		send_item(CMD_DATA, 8'hD3);
		send_item(CMD_DATA, 8'h0F);
		send_item(CMD_START, 8'hAA);
		send_item(CMD_DATA, 8'h35);
		send_item(CMD_END, 8'hFF);
	endtask

	// one pixel per line: last values clear every two bytes
	task automatic test_line_clear();
		set_config(16'd1, CAPACITY_MAX);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		send_item(CMD_START, 8'h00);
		send_item(CMD_DATA, 8'hCC);
		send_item(CMD_DATA, 8'hCC);
		send_item(CMD_DATA, 8'hF8);
		send_item(CMD_DATA, 8'h0C);
		send_item(CMD_END, 8'h00);
	endtask

	// zero capacity drops everything, a small one drops past its end, also after a report
	task automatic test_capacity_limit();
		set_config(16'd2, 24'd0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_item(CMD_START, 8'h00);
		send_item(CMD_DATA, 8'h5F);
		send_item(CMD_DATA, 8'h77);
		send_item(CMD_END, 8'h00);
		set_config(16'd2, 24'd3);
		send_item(CMD_START, 8'h00);
		send_item(CMD_DATA, 8'hC9);
		send_item(CMD_DATA, 8'hF3);
		send_item(CMD_DATA, 8'h1A);
		send_item(CMD_END, 8'h00);
		send_item(CMD_DATA, 8'h80);
		send_item(CMD_END, 8'h00);
	endtask

	task automatic hold_receiver(input int cycles);
		@(posedge clk);
		rx_block = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_block = 1'b0;
	endtask

	// receiver stops for a long stretch while two-byte items keep coming
	task automatic test_backpressure();
		set_config(LINE_WIDTH_RESET, CAPACITY_RESET);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_item(CMD_START, 8'h00);
		fork
			hold_receiver(200);
			begin
				for (int i = 0; i < 40; i++)
					send_item(CMD_DATA, {4'($urandom_range(0, 12)), 4'($urandom_range(0, 12))});
			end
		join
		send_item(CMD_END, 8'h00);
	endtask

	task automatic random_frame(input int n);
		int r;
		send_item(CMD_START, 8'($urandom));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_item(CMD_SPARE, 8'($urandom));
			else if (r < 6)
				send_item(CMD_END, 8'($urandom));
			else if (r < 8)
				send_item(CMD_START, 8'($urandom));
			else if (r < 20)
				send_item(CMD_DATA, 8'($urandom));
			else
				send_item(CMD_DATA, {pick_nibble(), pick_nibble()});
		end
		send_item(CMD_END, 8'($urandom));
	endtask

	task automatic test_random_streams();
		int start_count;
		logic [15:0] width;
		logic [23:0] cap;
		start_count = items_sent;
		for (int p = 0; items_sent - start_count < RANDOM_ITEMS; p++) begin
			case (p % 5)
				0: width = 16'd1;
				1: width = 16'($urandom_range(2, 8));
				2: width = 16'd0;
				3: width = 16'hFFFF;
				default: width = 16'($urandom_range(1, 40));
			endcase
			case (p % 4)
				0: cap = CAPACITY_MAX;
				1: cap = 24'($urandom_range(0, 80));
				2: cap = 24'($urandom_range(1, 400));
				default: cap = 24'($urandom);
			endcase
			set_config(width, cap);
			tx_idle = p[0];
			rx_idle = p[1] | p[2];
			for (int f = 0; f < 3; f++)
				random_frame($urandom_range(5, 45));
		end
	endtask

	initial begin
		line_width = LINE_WIDTH_RESET;
		frame_cap = CAPACITY_RESET;
		clear_decoder();
		rx_block = 1'b0;
		rx_wait = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_decode_basics();
		test_line_clear();
		test_capacity_limit();
		test_backpressure();
		test_random_streams();
		drain_results();
		$display("sent %0d items; checked %0d results (%0d dropped bytes, %0d frame reports)",
			items_sent, results_seen, drops_seen, reports_seen);
		$display("line widths 0..65535 and capacities 0..max, with and without stalls");
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
